### src/i2cms_pkg.sv
// Shared types, status codes and constants for the I2C master transaction sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

	// Field widths
	localparam int unsigned FUNC_W       = 2;
	localparam int unsigned LOAD_INDEX_W = 4;
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned SENT_W       = 5;
	localparam int unsigned RECV_W       = 8;
	localparam int unsigned CFG_INDEX_W  = 2;

	// Default command store depth
	localparam int unsigned COMMAND_DEPTH_DEF = 16;

	// Item function codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_START  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CMD_LEN    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RSP_LEN    = 2'd2;

	// Bus controller status codes
	localparam logic [BYTE_W-1:0] ST_BUS_ERROR   = 8'h00;
	localparam logic [BYTE_W-1:0] ST_START       = 8'h08;
	localparam logic [BYTE_W-1:0] ST_REP_START   = 8'h10;
	localparam logic [BYTE_W-1:0] ST_SLA_W_ACK   = 8'h18;
	localparam logic [BYTE_W-1:0] ST_SLA_W_NACK  = 8'h20;
	localparam logic [BYTE_W-1:0] ST_DATA_W_ACK  = 8'h28;
	localparam logic [BYTE_W-1:0] ST_DATA_W_NACK = 8'h30;
	localparam logic [BYTE_W-1:0] ST_SLA_R_ACK   = 8'h40;
	localparam logic [BYTE_W-1:0] ST_SLA_R_NACK  = 8'h48;
	localparam logic [BYTE_W-1:0] ST_DATA_R_ACK  = 8'h50;
	localparam logic [BYTE_W-1:0] ST_DATA_R_NACK = 8'h58;

	// Configuration registers
	typedef struct packed {
		logic [BYTE_W-1:0] slave_address_byte;
		logic [SENT_W-1:0] command_length;
		logic [RECV_W-1:0] response_length;
	} cfg_t;

	// Transaction progress
	typedef struct packed {
		logic [SENT_W-1:0] sent_count;
		logic [RECV_W-1:0] received_count;
		logic              read_phase;
		logic              ended;
	} seq_state_t;

	// One result item
	typedef struct packed {
		logic              set_start;
		logic              set_stop;
		logic              set_ack;
		logic              clear_start;
		logic              clear_ack;
		logic              write_valid;
		logic [BYTE_W-1:0] write_data;
		logic              response_valid;
		logic [BYTE_W-1:0] response_byte;
		logic              transaction_done;
		logic              nothing_to_do;
		logic              unknown_status;
	} result_t;

endpackage

### src/i2cms_store.sv
// Command byte register file: one write port, one combinational read port.
`timescale 1ns / 1ps

module i2cms_store #(
	parameter int unsigned COMMAND_DEPTH = i2cms_pkg::COMMAND_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [i2cms_pkg::LOAD_INDEX_W-1:0]  waddr,
	input  logic [i2cms_pkg::BYTE_W-1:0]        wdata,
	input  logic [i2cms_pkg::SENT_W-1:0]        raddr,
	output logic [i2cms_pkg::BYTE_W-1:0]        rdata
);
	import i2cms_pkg::*;

	// Only positions a load index can reach are ever written
	localparam int unsigned REACH       = 2 ** LOAD_INDEX_W;
	localparam int unsigned STORE_DEPTH = (COMMAND_DEPTH < REACH) ? COMMAND_DEPTH : REACH;
	localparam int unsigned AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [BYTE_W-1:0] mem [STORE_DEPTH];
	logic              wr_hit;
	logic              rd_hit;

	assign wr_hit = SENT_W'(waddr) < SENT_W'(STORE_DEPTH);
	assign rd_hit = raddr < SENT_W'(STORE_DEPTH);

	// Write port; out-of-range loads are dropped
	always_ff @(posedge clk) begin
		if (we && wr_hit) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
	end

	// Read port; beyond the store reads as zero
	assign rdata = rd_hit ? mem[raddr[AW-1:0]] : '0;

endmodule

### src/i2cms_decode.sv
// Item decode: result fields and next transaction progress for one item.
`timescale 1ns / 1ps

module i2cms_decode (
	input  logic [i2cms_pkg::FUNC_W-1:0]  func,
	input  logic [i2cms_pkg::BYTE_W-1:0]  status_code,
	input  logic [i2cms_pkg::BYTE_W-1:0]  data_in,
	input  i2cms_pkg::cfg_t               cfg,
	input  i2cms_pkg::seq_state_t         cur,
	input  logic [i2cms_pkg::BYTE_W-1:0]  store_rdata,
	output logic                          store_we,
	output logic [i2cms_pkg::SENT_W-1:0]  store_raddr,
	output i2cms_pkg::seq_state_t         nxt,
	output i2cms_pkg::result_t            res
);
	import i2cms_pkg::*;

	logic [SENT_W-1:0] sent_inc;
	logic [RECV_W-1:0] recv_inc;

	assign sent_inc = cur.sent_count + SENT_W'(1);
	assign recv_inc = cur.received_count + RECV_W'(1);

	// A data-acked event fetches the byte after the one just counted
	assign store_raddr = (status_code == ST_DATA_W_ACK) ? sent_inc : cur.sent_count;

	always_comb begin
		res      = '0;
		nxt      = cur;
		store_we = 1'b0;
		case (func)
			FUNC_LOAD: begin
				store_we = 1'b1;
			end
			FUNC_START: begin
				res.clear_start    = 1'b1;
				res.clear_ack      = 1'b1;
				nxt.sent_count     = '0;
				nxt.received_count = '0;
				nxt.ended          = 1'b0;
				nxt.read_phase     = (cfg.command_length == '0);
				if ((cfg.command_length == '0) && (cfg.response_length == '0)) begin
					res.nothing_to_do = 1'b1;
				end else begin
					res.set_start = 1'b1;
				end
			end
			FUNC_STATUS: begin
				case (status_code)
					ST_START: begin
						res.write_valid = 1'b1;
						res.write_data  = cfg.slave_address_byte |
						                  {{(BYTE_W-1){1'b0}}, cur.read_phase};
						res.set_ack     = 1'b1;
						res.clear_start = 1'b1;
					end
					ST_SLA_W_ACK: begin
						res.write_valid = 1'b1;
						res.write_data  = store_rdata;
					end
					ST_REP_START: begin
					end
					ST_SLA_W_NACK, ST_DATA_W_NACK, ST_SLA_R_NACK: begin
						res.set_stop = 1'b1;
						res.set_ack  = 1'b1;
					end
					ST_DATA_W_ACK: begin
						nxt.sent_count = sent_inc;
						if (sent_inc == cfg.command_length) begin
							res.set_stop = 1'b1;
							res.set_ack  = 1'b1;
							if (cfg.response_length != '0) begin
								// restart for the read phase
								res.set_start  = 1'b1;
								nxt.read_phase = 1'b1;
							end else begin
								nxt.ended            = 1'b1;
								res.transaction_done = 1'b1;
							end
						end else begin
							res.write_valid = 1'b1;
							res.write_data  = store_rdata;
							res.set_ack     = 1'b1;
						end
					end
					ST_SLA_R_ACK: begin
						res.set_ack = 1'b1;
					end
					ST_DATA_R_ACK: begin
						res.response_valid = 1'b1;
						res.response_byte  = data_in;
						nxt.received_count = recv_inc;
						// nack the last expected byte
						if (recv_inc != cfg.response_length) begin
							res.set_ack = 1'b1;
						end else begin
							res.clear_ack = 1'b1;
						end
					end
					ST_DATA_R_NACK: begin
						res.set_stop         = 1'b1;
						res.set_ack          = 1'b1;
						nxt.ended            = 1'b1;
						res.transaction_done = 1'b1;
					end
					ST_BUS_ERROR: begin
						res.set_stop = 1'b1;
					end
					default: begin
						res.unknown_status = 1'b1;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

endmodule

### src/i2c_master_transaction_sequencer.sv
// Top level: input register, item decode, command store and result register.
// An accepted item is held in the input register, then its result is registered.
// Throughput: one item per cycle unless out_ready stalls the result register;
// the decode and counter update between the two registers set that figure.
// Reset clears handshake state, configuration registers and counters; the
// command store is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer #(
	parameter int unsigned COMMAND_DEPTH = i2cms_pkg::COMMAND_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [i2cms_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [i2cms_pkg::BYTE_W-1:0]        cfg_data,
	// input items
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [i2cms_pkg::FUNC_W-1:0]        func,
	input  logic [i2cms_pkg::LOAD_INDEX_W-1:0]  load_index,
	input  logic [i2cms_pkg::BYTE_W-1:0]        load_byte,
	input  logic [i2cms_pkg::BYTE_W-1:0]        status_code,
	input  logic [i2cms_pkg::BYTE_W-1:0]        data_in,
	// result items
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                set_start,
	output logic                                set_stop,
	output logic                                set_ack,
	output logic                                clear_start,
	output logic                                clear_ack,
	output logic                                write_valid,
	output logic [i2cms_pkg::BYTE_W-1:0]        write_data,
	output logic                                response_valid,
	output logic [i2cms_pkg::BYTE_W-1:0]        response_byte,
	output logic                                transaction_done,
	output logic                                nothing_to_do,
	output logic                                unknown_status
);
	import i2cms_pkg::*;

	cfg_t                cfg_q;
	seq_state_t          state_q;
	seq_state_t          state_nxt;

	logic                valid_s1;
	logic [FUNC_W-1:0]   func_s1;
	logic [LOAD_INDEX_W-1:0] load_index_s1;
	logic [BYTE_W-1:0]   load_byte_s1;
	logic [BYTE_W-1:0]   status_code_s1;
	logic [BYTE_W-1:0]   data_in_s1;

	logic                valid_s2;
	result_t             result_s2;
	result_t             result_nxt;

	logic                advance;
	logic                store_we;
	logic [SENT_W-1:0]   store_raddr;
	logic [BYTE_W-1:0]   store_rdata;

	// Handshake: stage 1 moves on whenever the result register is free or drained
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SLAVE_ADDR: cfg_q.slave_address_byte <= cfg_data;
				CFG_CMD_LEN:    cfg_q.command_length     <= cfg_data[SENT_W-1:0];
				CFG_RSP_LEN:    cfg_q.response_length    <= cfg_data[RECV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1        <= func;
			load_index_s1  <= load_index;
			load_byte_s1   <= load_byte;
			status_code_s1 <= status_code;
			data_in_s1     <= data_in;
		end
	end

	i2cms_store #(
		.COMMAND_DEPTH(COMMAND_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we && advance),
		.waddr(load_index_s1),
		.wdata(load_byte_s1),
		.raddr(store_raddr),
		.rdata(store_rdata)
	);

	i2cms_decode u_decode (
		.func       (func_s1),
		.status_code(status_code_s1),
		.data_in    (data_in_s1),
		.cfg        (cfg_q),
		.cur        (state_q),
		.store_rdata(store_rdata),
		.store_we   (store_we),
		.store_raddr(store_raddr),
		.nxt        (state_nxt),
		.res        (result_nxt)
	);

	// Transaction progress and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	assign set_start        = result_s2.set_start;
	assign set_stop         = result_s2.set_stop;
	assign set_ack          = result_s2.set_ack;
	assign clear_start      = result_s2.clear_start;
	assign clear_ack        = result_s2.clear_ack;
	assign write_valid      = result_s2.write_valid;
	assign write_data       = result_s2.write_data;
	assign response_valid   = result_s2.response_valid;
	assign response_byte    = result_s2.response_byte;
	assign transaction_done = result_s2.transaction_done;
	assign nothing_to_do    = result_s2.nothing_to_do;
	assign unknown_status   = result_s2.unknown_status;

	// A refused start never requests a start condition
	a_refuse_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(nothing_to_do && set_start))
		else $error("refused start also requests start");

	// A completion leaves the transaction marked as ended
	a_done_marks_ended: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result_nxt.transaction_done) |=> state_q.ended)
		else $error("completion did not mark transaction ended");

	// A received byte and a byte to transmit never share one result
	a_rsp_excl_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(response_valid && write_valid))
		else $error("response and transmit byte in one result");

	// Entering the read phase comes with a restart request
	a_read_phase_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !state_q.read_phase && state_nxt.read_phase &&
		 (func_s1 == FUNC_STATUS)) |=> (set_start && set_stop))
		else $error("read phase entered without restart");

endmodule

### test/i2c_master_transaction_sequencer_tb.sv
// Self-checking testbench for the I2C master transaction sequencer.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_tb;
	import i2cms_pkg::*;

	localparam int unsigned CMD_DEPTH = COMMAND_DEPTH_DEF;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int SIDE_IN = 0;
	localparam int SIDE_OUT = 1;
	localparam int DRAIN_CYCLES = 4;

	// One input item
	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [LOAD_INDEX_W-1:0] load_index;
		logic [BYTE_W-1:0]       load_byte;
		logic [BYTE_W-1:0]       status_code;
		logic [BYTE_W-1:0]       data_in;
	} item_t;

	// Directed stimulus row; want is used only where typed is set
	typedef struct {
		int      phase;
		item_t   stim;
		bit      typed;
		result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [BYTE_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [FUNC_W-1:0] func;
	logic [LOAD_INDEX_W-1:0] load_index;
	logic [BYTE_W-1:0] load_byte;
	logic [BYTE_W-1:0] status_code;
	logic [BYTE_W-1:0] data_in;
	logic out_valid;
	logic out_ready;
	logic set_start;
	logic set_stop;
	logic set_ack;
	logic clear_start;
	logic clear_ack;
	logic write_valid;
	logic [BYTE_W-1:0] write_data;
	logic response_valid;
	logic [BYTE_W-1:0] response_byte;
	logic transaction_done;
	logic nothing_to_do;
	logic unknown_status;

	// Predictor copy of configuration and progress
	logic [BYTE_W-1:0] cfg_addr;
	logic [SENT_W-1:0] cfg_cmd_len;
	logic [RECV_W-1:0] cfg_rsp_len;
	logic [BYTE_W-1:0] cmd_bytes [CMD_DEPTH];
	bit                cmd_written [CMD_DEPTH];
	logic [SENT_W-1:0] sent_cnt;
	logic [RECV_W-1:0] rcvd_cnt;
	logic              reading;
	logic              xfer_ended;

	result_t   actions_due [$];
	stim_row_t directed_rows [$];
	int        mismatches;
	int        items_sent;
	int        calm_left [2];
	bit        seq_broken;

	i2c_master_transaction_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.load_index(load_index),
		.load_byte(load_byte),
		.status_code(status_code),
		.data_in(data_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.set_start(set_start),
		.set_stop(set_stop),
		.set_ack(set_ack),
		.clear_start(clear_start),
		.clear_ack(clear_ack),
		.write_valid(write_valid),
		.write_data(write_data),
		.response_valid(response_valid),
		.response_byte(response_byte),
		.transaction_done(transaction_done),
		.nothing_to_do(nothing_to_do),
		.unknown_status(unknown_status)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#5000000;
		$display("FAIL i2c_master_transaction_sequencer");
		$finish;
	end

	// Random wait per item, with occasional stretches of none
	function automatic int draw_wait(int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			calm_left[side] = $urandom_range(10, 60);
		return $urandom_range(0, 13);
	endfunction

	function automatic item_t mk_item(logic [FUNC_W-1:0] f, logic [LOAD_INDEX_W-1:0] idx,
			logic [BYTE_W-1:0] lb, logic [BYTE_W-1:0] sc, logic [BYTE_W-1:0] di);
		item_t it;
		it.func = f;
		it.load_index = idx;
		it.load_byte = lb;
		it.status_code = sc;
		it.data_in = di;
		return it;
	endfunction

	function automatic result_t actions(bit ss, bit sp, bit sa, bit cs, bit ca, bit wv,
			logic [BYTE_W-1:0] wd, bit dn, bit nt, bit un);
		result_t r;
		r = '0;
		r.set_start = ss;
		r.set_stop = sp;
		r.set_ack = sa;
		r.clear_start = cs;
		r.clear_ack = ca;
		r.write_valid = wv;
		r.write_data = wd;
		r.transaction_done = dn;
		r.nothing_to_do = nt;
		r.unknown_status = un;
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] stored_at(logic [SENT_W-1:0] pos);
		if (pos < CMD_DEPTH)
			return cmd_bytes[pos[LOAD_INDEX_W-1:0]];
		return '0;
	endfunction

	// Controller actions for one item; advances the predicted progress
	function automatic result_t predict_actions(item_t it);
		result_t r;
		r = '0;
		case (it.func)
			FUNC_LOAD: begin
				if (it.load_index < CMD_DEPTH) begin
					cmd_bytes[it.load_index] = it.load_byte;
					cmd_written[it.load_index] = 1'b1;
				end
			end
			FUNC_START: begin
				r.clear_start = 1'b1;
				r.clear_ack = 1'b1;
				sent_cnt = '0;
				rcvd_cnt = '0;
				xfer_ended = 1'b0;
				reading = (cfg_cmd_len == 0);
				if (reading && cfg_rsp_len == 0)
					r.nothing_to_do = 1'b1;
				else
					r.set_start = 1'b1;
			end
			FUNC_STATUS: begin
				case (it.status_code)
					ST_START: begin
						r.write_valid = 1'b1;
						r.write_data = cfg_addr | {7'd0, reading};
						r.set_ack = 1'b1;
						r.clear_start = 1'b1;
					end
					ST_SLA_W_ACK: begin
						r.write_valid = 1'b1;
						r.write_data = stored_at(sent_cnt);
					end
					ST_REP_START: ;
					ST_SLA_W_NACK, ST_DATA_W_NACK, ST_SLA_R_NACK: begin
						r.set_stop = 1'b1;
						r.set_ack = 1'b1;
					end
					ST_DATA_W_ACK: begin
						sent_cnt = sent_cnt + 1'b1;
						if (sent_cnt == cfg_cmd_len) begin
							// last command byte: restart for reading or finish
							r.set_stop = 1'b1;
							r.set_ack = 1'b1;
							if (cfg_rsp_len != 0) begin
								r.set_start = 1'b1;
								reading = 1'b1;
							end else begin
								xfer_ended = 1'b1;
								r.transaction_done = 1'b1;
							end
						end else begin
							r.write_valid = 1'b1;
							r.write_data = stored_at(sent_cnt);
							r.set_ack = 1'b1;
						end
					end
					ST_SLA_R_ACK: r.set_ack = 1'b1;
					ST_DATA_R_ACK: begin
						r.response_valid = 1'b1;
						r.response_byte = it.data_in;
						rcvd_cnt = rcvd_cnt + 1'b1;
						if (rcvd_cnt != cfg_rsp_len)
							r.set_ack = 1'b1;
						else
							r.clear_ack = 1'b1;
					end
					ST_DATA_R_NACK: begin
						r.set_stop = 1'b1;
						r.set_ack = 1'b1;
						xfer_ended = 1'b1;
						r.transaction_done = 1'b1;
					end
					ST_BUS_ERROR: r.set_stop = 1'b1;
					default: r.unknown_status = 1'b1;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	// Drive one item, wait for acceptance, queue its expected actions
	task automatic send_one(item_t it, bit typed, result_t typed_res);
		int gap;
		result_t want;
		gap = draw_wait(SIDE_IN);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= it.func;
		load_index <= it.load_index;
		load_byte <= it.load_byte;
		status_code <= it.status_code;
		data_in <= it.data_in;
		do @(posedge clk); while (in_ready !== 1'b1);
		want = predict_actions(it);
		if (typed)
			want = typed_res;
		actions_due.push_back(want);
		if (it.func != FUNC_UNUSED)
			items_sent++;
	endtask

	// Never let a status item read a command entry that was not loaded
	task automatic issue(item_t it);
		bit reads_store;
		logic [SENT_W-1:0] pos;
		reads_store = 1'b0;
		pos = sent_cnt;
		if (it.func == FUNC_STATUS) begin
			if (it.status_code == ST_SLA_W_ACK) begin
				reads_store = 1'b1;
			end else if (it.status_code == ST_DATA_W_ACK) begin
				pos = sent_cnt + 1'b1;
				reads_store = (pos != cfg_cmd_len);
			end
		end
		if (reads_store && pos < CMD_DEPTH && !cmd_written[pos[LOAD_INDEX_W-1:0]])
			send_one(mk_item(FUNC_LOAD, pos[LOAD_INDEX_W-1:0], BYTE_W'($urandom),
				BYTE_W'($urandom), BYTE_W'($urandom)), 1'b0, '0);
		send_one(it, 1'b0, '0);
	endtask

	function automatic item_t status_item(logic [BYTE_W-1:0] code);
		return mk_item(FUNC_STATUS, LOAD_INDEX_W'($urandom), BYTE_W'($urandom), code,
			BYTE_W'($urandom));
	endfunction

	function automatic logic [BYTE_W-1:0] pick_code();
		case ($urandom_range(0, 12))
			0: return ST_BUS_ERROR;
			1: return ST_START;
			2: return ST_REP_START;
			3: return ST_SLA_W_ACK;
			4: return ST_SLA_W_NACK;
			5: return ST_DATA_W_ACK;
			6: return ST_DATA_W_NACK;
			7: return ST_SLA_R_ACK;
			8: return ST_SLA_R_NACK;
			9: return ST_DATA_R_ACK;
			10: return ST_DATA_R_NACK;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic item_t noise_item();
		return mk_item(FUNC_W'($urandom_range(0, 3)), LOAD_INDEX_W'($urandom),
			BYTE_W'($urandom), pick_code(), BYTE_W'($urandom));
	endfunction

	// One step of a well-formed sequence; may be preceded by noise or cut off
	task automatic step(logic [BYTE_W-1:0] code);
		if (seq_broken)
			return;
		if ($urandom_range(0, 79) == 0) begin
			seq_broken = 1'b1;
			return;
		end
		if ($urandom_range(0, 9) == 0)
			issue(noise_item());
		issue(status_item(code));
	endtask

	// Write and/or read transaction with random content, per the configured lengths
	task automatic run_transaction();
		int i;
		seq_broken = 1'b0;
		for (i = 0; i < CMD_DEPTH && i < cfg_cmd_len; i++)
			if (!cmd_written[i] || $urandom_range(0, 2) == 0)
				issue(mk_item(FUNC_LOAD, LOAD_INDEX_W'(i), BYTE_W'($urandom),
					BYTE_W'($urandom), BYTE_W'($urandom)));
		issue(mk_item(FUNC_START, LOAD_INDEX_W'($urandom), BYTE_W'($urandom),
			BYTE_W'($urandom), BYTE_W'($urandom)));
		if (cfg_cmd_len != 0) begin
			step(ST_START);
			step(ST_SLA_W_ACK);
			for (i = 0; i < cfg_cmd_len; i++)
				step(ST_DATA_W_ACK);
			if (cfg_rsp_len != 0)
				step(ST_REP_START);
		end
		if (cfg_rsp_len != 0) begin
			step(ST_START);
			step(ST_SLA_R_ACK);
			for (i = 0; i < cfg_rsp_len; i++)
				step(ST_DATA_R_ACK);
			step(ST_DATA_R_NACK);
		end
	endtask

	// Wait until every expected item has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (actions_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [BYTE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_SLAVE_ADDR: cfg_addr = val;
			CFG_CMD_LEN: cfg_cmd_len = val[SENT_W-1:0];
			CFG_RSP_LEN: cfg_rsp_len = val;
			default: ;
		endcase
	endtask

	task automatic write_config(logic [BYTE_W-1:0] addr, logic [SENT_W-1:0] clen,
			logic [RECV_W-1:0] rlen);
		cfg_write(CFG_SLAVE_ADDR, addr);
		cfg_write(CFG_CMD_LEN, {3'd0, clen});
		cfg_write(CFG_RSP_LEN, rlen);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(int ph, item_t s, bit t, result_t w);
		stim_row_t row;
		row.phase = ph;
		row.stim = s;
		row.typed = t;
		row.want = w;
		directed_rows.push_back(row);
	endtask

	task automatic check_field(string fname, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
			mismatches++;
		end
	endtask

	// Result side: random stalls, compare each item with the oldest expectation
	initial begin : result_side
		int stall;
		result_t got;
		result_t want;
		out_ready = 1'b0;
		forever begin
			stall = draw_wait(SIDE_OUT);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.set_start = set_start;
			got.set_stop = set_stop;
			got.set_ack = set_ack;
			got.clear_start = clear_start;
			got.clear_ack = clear_ack;
			got.write_valid = write_valid;
			got.write_data = write_data;
			got.response_valid = response_valid;
			got.response_byte = response_byte;
			got.transaction_done = transaction_done;
			got.nothing_to_do = nothing_to_do;
			got.unknown_status = unknown_status;
			if (actions_due.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual %h", $time, got);
				mismatches++;
			end else begin
				want = actions_due.pop_front();
				check_field("set_start", want.set_start, got.set_start);
				check_field("set_stop", want.set_stop, got.set_stop);
				check_field("set_ack", want.set_ack, got.set_ack);
				check_field("clear_start", want.clear_start, got.clear_start);
				check_field("clear_ack", want.clear_ack, got.clear_ack);
				check_field("write_valid", want.write_valid, got.write_valid);
				check_field("write_data", want.write_data, got.write_data);
				check_field("response_valid", want.response_valid, got.response_valid);
				check_field("response_byte", want.response_byte, got.response_byte);
				check_field("transaction_done", want.transaction_done, got.transaction_done);
				check_field("nothing_to_do", want.nothing_to_do, got.nothing_to_do);
				check_field("unknown_status", want.unknown_status, got.unknown_status);
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		int cur_phase;
		int p;
		int goal;
		int k;
		logic [BYTE_W-1:0] addr;
		logic [SENT_W-1:0] clen;
		logic [RECV_W-1:0] rlen;
		result_t none;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = '0;
		load_index = '0;
		load_byte = '0;
		status_code = '0;
		data_in = '0;
		cfg_addr = '0;
		cfg_cmd_len = '0;
		cfg_rsp_len = '0;
		sent_cnt = '0;
		rcvd_cnt = '0;
		reading = 1'b0;
		xfer_ended = 1'b0;
		for (k = 0; k < CMD_DEPTH; k++)
			cmd_written[k] = 1'b0;
		mismatches = 0;
		items_sent = 0;
		none = '0;

		// Reset configuration: refused start, odd items, bus error, unknown code
		add_row(0, mk_item(FUNC_START, 0, 0, 0, 0), 1,
			actions(0, 0, 0, 1, 1, 0, 8'h00, 0, 1, 0));
		add_row(0, mk_item(FUNC_UNUSED, 4'hF, 8'hFF, 8'hFF, 8'hFF), 1, none);
		add_row(0, mk_item(FUNC_LOAD, 4'hF, 8'hFF, 0, 0), 1, none);
		add_row(0, mk_item(FUNC_LOAD, 4'h0, 8'h00, 0, 0), 1, none);
		add_row(0, mk_item(FUNC_STATUS, 0, 0, ST_BUS_ERROR, 8'h00), 1,
			actions(0, 1, 0, 0, 0, 0, 8'h00, 0, 0, 0));
		add_row(0, mk_item(FUNC_STATUS, 0, 0, 8'hFF, 8'hFF), 1,
			actions(0, 0, 0, 0, 0, 0, 8'h00, 0, 0, 1));
		add_row(0, mk_item(FUNC_STATUS, 0, 0, ST_REP_START, 0), 1, none);
		add_row(0, mk_item(FUNC_STATUS, 0, 0, ST_DATA_R_ACK, 8'hA5), 0, none);
		// Two command bytes, then restart and two response bytes
		add_row(1, mk_item(FUNC_LOAD, 4'h1, 8'h5A, 0, 0), 1, none);
		add_row(1, mk_item(FUNC_START, 0, 0, 0, 0), 1,
			actions(1, 0, 0, 1, 1, 0, 8'h00, 0, 0, 0));
		add_row(1, mk_item(FUNC_STATUS, 0, 0, ST_START, 0), 1,
			actions(0, 0, 1, 1, 0, 1, 8'hFE, 0, 0, 0));
		add_row(1, mk_item(FUNC_STATUS, 0, 0, ST_SLA_W_ACK, 0), 0, none);
		add_row(1, mk_item(FUNC_STATUS, 0, 0, ST_DATA_W_ACK, 0), 0, none);
		add_row(1, mk_item(FUNC_STATUS, 0, 0, ST_DATA_W_ACK, 0), 0, none);
		add_row(1, mk_item(FUNC_STATUS, 0, 0, ST_REP_START, 0), 0, none);
		add_row(1, mk_item(FUNC_STATUS, 0, 0, ST_START, 0), 1,
			actions(0, 0, 1, 1, 0, 1, 8'hFF, 0, 0, 0));
		add_row(1, mk_item(FUNC_STATUS, 0, 0, ST_SLA_R_ACK, 0), 1,
			actions(0, 0, 1, 0, 0, 0, 8'h00, 0, 0, 0));
		add_row(1, mk_item(FUNC_STATUS, 0, 0, ST_DATA_R_ACK, 8'h00), 0, none);
		add_row(1, mk_item(FUNC_STATUS, 0, 0, ST_DATA_R_ACK, 8'hFF), 0, none);
		add_row(1, mk_item(FUNC_STATUS, 0, 0, ST_DATA_R_NACK, 0), 1,
			actions(0, 1, 1, 0, 0, 0, 8'h00, 1, 0, 0));
		add_row(1, mk_item(FUNC_STATUS, 0, 0, ST_SLA_W_NACK, 0), 1,
			actions(0, 1, 1, 0, 0, 0, 8'h00, 0, 0, 0));
		add_row(1, mk_item(FUNC_STATUS, 0, 0, ST_DATA_W_NACK, 0), 1,
			actions(0, 1, 1, 0, 0, 0, 8'h00, 0, 0, 0));
		add_row(1, mk_item(FUNC_STATUS, 0, 0, ST_SLA_R_NACK, 0), 1,
			actions(0, 1, 1, 0, 0, 0, 8'h00, 0, 0, 0));
		// Write-only transaction of one byte
		add_row(2, mk_item(FUNC_START, 0, 0, 0, 0), 1,
			actions(1, 0, 0, 1, 1, 0, 8'h00, 0, 0, 0));
		add_row(2, mk_item(FUNC_STATUS, 0, 0, ST_SLA_W_ACK, 0), 0, none);
		add_row(2, mk_item(FUNC_STATUS, 0, 0, ST_DATA_W_ACK, 0), 1,
			actions(0, 1, 1, 0, 0, 0, 8'h00, 1, 0, 0));

		// Reset
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		cur_phase = 0;
		foreach (directed_rows[k]) begin
			if (directed_rows[k].phase != cur_phase) begin
				drain();
				cur_phase = directed_rows[k].phase;
				if (cur_phase == 1)
					write_config(8'hFE, 5'd2, 8'd2);
				else
					write_config(8'h00, 5'd1, 8'd0);
			end
			send_one(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].want);
		end

		// Random part, one configuration per phase
		for (p = 0; p < 11; p++) begin
			drain();
			addr = BYTE_W'($urandom_range(0, 254));
			clen = SENT_W'($urandom_range(0, 16));
			rlen = ($urandom_range(0, 4) != 0) ? RECV_W'($urandom_range(0, 5)) :
				RECV_W'($urandom_range(0, 255));
			case (p)
				0: write_config(8'hFE, 5'd16, 8'd255);
				1: write_config(8'h00, 5'd0, 8'd0);
				2: write_config(addr, 5'd16, 8'd0);
				3: write_config(addr, 5'd0, 8'd255);
				default: write_config(addr, clen, rlen);
			endcase
			// long runs with both lengths zero wrap both counters
			if (p == 1) begin
				repeat (260) issue(status_item(ST_DATA_R_ACK));
				repeat (40) issue(status_item(ST_DATA_W_ACK));
			end
			goal = items_sent + 110;
			while (items_sent < goal) begin
				if ($urandom_range(0, 3) != 0)
					run_transaction();
				else
					repeat ($urandom_range(1, 8)) issue(noise_item());
			end
		end

		// Wind down
		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && actions_due.size() == 0)
			$display("PASS i2c_master_transaction_sequencer");
		else
			$display("FAIL i2c_master_transaction_sequencer");
		$finish;
	end

endmodule

### filelist.f
src/i2cms_pkg.sv
src/i2cms_store.sv
src/i2cms_decode.sv
src/i2c_master_transaction_sequencer.sv
test/i2c_master_transaction_sequencer_tb.sv
